// ----- rtl/core/tmc_pkg.sv -----
// shared types, opcodes and cordic constants for the transform matrix composer
`timescale 1ns / 1ps

package tmc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CORDIC_STEPS  = 24;
	localparam int CORDIC_W      = 34;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [2:0] OP_IDENT = 3'd0;
	localparam logic [2:0] OP_ROT_X = 3'd1;
	localparam logic [2:0] OP_ROT_Y = 3'd2;
	localparam logic [2:0] OP_ROT_Z = 3'd3;
	localparam logic [2:0] OP_SCALE = 3'd4;
	localparam logic [2:0] OP_TRANS = 3'd5;

	// arctangent of 2^-i, 2^32 units per turn
	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
		32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [15:0] angle;
		logic signed [31:0] x_value;
		logic signed [31:0] y_value;
		logic signed [31:0] z_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         row_index;
		logic signed [31:0] col_zero;
		logic signed [31:0] col_one;
		logic signed [31:0] col_two;
		logic signed [31:0] col_three;
		logic               saturated;
		logic               last_row;
	} out_item_t;

endpackage

// ----- rtl/core/transform_matrix_composer.sv -----
// 4x4 fixed-point transform composer: cordic sin/cos and shared-multiplier matrix product
// flow from accept to first row valid: identity and unused opcodes go straight to row load; scale
// and translate compute 64 products through one 32x32 multiplier, then drain, commit and row load;
// rotations first run 24 cordic steps and a rounding step; each row is loaded, then held until out_ready
// throughput: one item at a time, in_ready high only while idle
// reset: arst_n clears control and loads the identity matrix
`timescale 1ns / 1ps

module transform_matrix_composer #(
	parameter int FRAC_BITS = tmc_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tmc_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output tmc_pkg::out_item_t out_item
);

	localparam int CW    = tmc_pkg::CORDIC_W;
	localparam int ACC_W = 67;
	localparam int SH    = 30 - FRAC_BITS;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [CW:0] ONE_C = (CW+1)'(1) <<< FRAC_BITS;

	typedef enum logic [2:0] {
		S_IDLE, S_CORD, S_FRAC, S_MAC, S_DRAIN, S_COMMIT, S_LOAD, S_EMIT
	} state_t;

	state_t state_q;
	logic [2:0] op_q;
	logic signed [31:0] xv_q, yv_q, zv_q, co_q, si_q;
	logic signed [CW-1:0] cx_q, cy_q, cz_q;
	logic [4:0] iter_q;
	logic [5:0] idx_q;
	logic [1:0] row_q;
	logic       flip_q, sat_q;
	logic signed [31:0] m_q [4][4];
	logic signed [31:0] next_q [16];

	logic signed [63:0]    prod_s1;
	logic                  v_s1;
	logic [1:0]            k_s1;
	logic [3:0]            rc_s1, rc_s2;
	logic signed [ACC_W-1:0] acc_q, sum_s2;
	logic                  v_s2;

	// angle fold into [-pi/2, pi/2]
	logic signed [16:0] ang_f;
	logic               flip_d;
	always_comb begin
		ang_f  = 17'(in_item.angle);
		flip_d = 1'b0;
		if (in_item.angle > 16'sd16384) begin
			ang_f  = 17'(in_item.angle) - 17'sd32768;
			flip_d = 1'b1;
		end else if (in_item.angle < -16'sd16384) begin
			ang_f  = 17'(in_item.angle) + 17'sd32768;
			flip_d = 1'b1;
		end
	end

	// cordic step
	logic signed [CW-1:0] dx, dy, at;
	assign dx = cy_q >>> iter_q;
	assign dy = cx_q >>> iter_q;
	assign at = CW'(signed'({1'b0, tmc_pkg::ATAN_TURNS[iter_q]}));

	// round cordic results to frac bits, clamp to [-1, 1] and negate when the angle was folded
	function automatic logic signed [31:0] to_frac(input logic signed [CW-1:0] v, input logic f);
		logic signed [CW:0] r;
		r = ((CW+1)'(v) + ((CW+1)'(1) <<< (SH - 1))) >>> SH;
		if (r > ONE_C) r = ONE_C;
		if (r < -ONE_C) r = -ONE_C;
		if (f) r = -r;
		return 32'(r);
	endfunction

	// operation matrix element at row idx[5:4], column idx[1:0]
	logic [1:0] tr, tk;
	logic signed [31:0] t_sel, m_sel;
	logic [1:0] rd_row;
	assign tr = idx_q[5:4];
	assign tk = idx_q[1:0];
	always_comb begin
		t_sel = (tr == tk) ? ONE : 32'sd0;
		case (op_q)
			tmc_pkg::OP_ROT_X: begin
				case ({tr, tk})
					4'd5:    t_sel = co_q;
					4'd6:    t_sel = -si_q;
					4'd9:    t_sel = si_q;
					4'd10:   t_sel = co_q;
					default: ;
				endcase
			end
			tmc_pkg::OP_ROT_Y: begin
				case ({tr, tk})
					4'd0:    t_sel = co_q;
					4'd2:    t_sel = si_q;
					4'd8:    t_sel = -si_q;
					4'd10:   t_sel = co_q;
					default: ;
				endcase
			end
			tmc_pkg::OP_ROT_Z: begin
				case ({tr, tk})
					4'd0:    t_sel = co_q;
					4'd1:    t_sel = -si_q;
					4'd4:    t_sel = si_q;
					4'd5:    t_sel = co_q;
					default: ;
				endcase
			end
			tmc_pkg::OP_SCALE: begin
				case ({tr, tk})
					4'd0:    t_sel = xv_q;
					4'd5:    t_sel = yv_q;
					4'd10:   t_sel = zv_q;
					default: ;
				endcase
			end
			tmc_pkg::OP_TRANS: begin
				case ({tr, tk})
					4'd3:    t_sel = xv_q;
					4'd7:    t_sel = yv_q;
					4'd11:   t_sel = zv_q;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// single element read port on the stored matrix: row idx[1:0] in S_MAC, else row_q
	assign rd_row = (state_q == S_MAC) ? idx_q[1:0] : row_q;
	assign m_sel  = m_q[rd_row][idx_q[3:2]];

	// multiply-accumulate pipeline
	always_ff @(posedge clk) begin
		prod_s1 <= t_sel * m_sel;
		k_s1    <= idx_q[1:0];
		rc_s1   <= {idx_q[5:4], idx_q[3:2]};
	end

	logic signed [ACC_W-1:0] acc_d;
	assign acc_d = ((k_s1 == 2'd0) ? ACC_W'(0) : acc_q) + ACC_W'(prod_s1);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			acc_q <= acc_d;
		end
		sum_s2 <= acc_d;
		rc_s2  <= rc_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_MAC);
			v_s2 <= v_s1 && (k_s1 == 2'd3);
		end
	end

	// round half up and saturate
	logic signed [ACC_W-1:0] rnd;
	logic                    ovf;
	assign rnd = (sum_s2 + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	assign ovf = !((rnd[ACC_W-1:31] == '0) || (rnd[ACC_W-1:31] == '1));

	always_ff @(posedge clk) begin
		if (v_s2) begin
			if (!ovf) next_q[rc_s2] <= 32'(rnd);
			else if (rnd[ACC_W-1]) next_q[rc_s2] <= 32'sh8000_0000;
			else next_q[rc_s2] <= 32'sh7fff_ffff;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= tmc_pkg::OP_IDENT;
			iter_q    <= '0;
			idx_q     <= '0;
			row_q     <= '0;
			flip_q    <= 1'b0;
			sat_q     <= 1'b0;
			out_valid <= 1'b0;
			out_item  <= '0;
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					m_q[r][c] <= (r == c) ? ONE : 32'sd0;
				end
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q   <= in_item.opcode;
						xv_q   <= in_item.x_value;
						yv_q   <= in_item.y_value;
						zv_q   <= in_item.z_value;
						sat_q  <= 1'b0;
						iter_q <= '0;
						idx_q  <= '0;
						row_q  <= '0;
						flip_q <= flip_d;
						cx_q   <= tmc_pkg::CORDIC_GAIN;
						cy_q   <= '0;
						cz_q   <= CW'(ang_f) <<< 16;
						case (in_item.opcode)
							tmc_pkg::OP_IDENT: begin
								for (int r = 0; r < 4; r++) begin
									for (int c = 0; c < 4; c++) begin
										m_q[r][c] <= (r == c) ? ONE : 32'sd0;
									end
								end
								state_q <= S_LOAD;
							end
							tmc_pkg::OP_ROT_X, tmc_pkg::OP_ROT_Y, tmc_pkg::OP_ROT_Z:
								state_q <= S_CORD;
							tmc_pkg::OP_SCALE, tmc_pkg::OP_TRANS:
								state_q <= S_MAC;
							default:
								state_q <= S_LOAD;
						endcase
					end
				end
				S_CORD: begin
					if (!cz_q[CW-1]) begin
						cx_q <= cx_q - dx;
						cy_q <= cy_q + dy;
						cz_q <= cz_q - at;
					end else begin
						cx_q <= cx_q + dx;
						cy_q <= cy_q - dy;
						cz_q <= cz_q + at;
					end
					if (iter_q == 5'(tmc_pkg::CORDIC_STEPS - 1)) begin
						state_q <= S_FRAC;
					end else begin
						iter_q <= iter_q + 5'd1;
					end
				end
				S_FRAC: begin
					co_q    <= to_frac(cx_q, flip_q);
					si_q    <= to_frac(cy_q, flip_q);
					state_q <= S_MAC;
				end
				S_MAC: begin
					idx_q <= idx_q + 6'd1;
					if (idx_q == 6'd63) begin
						iter_q  <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// wait for the last element to clear round and saturate
					if (v_s2 && ovf) sat_q <= 1'b1;
					if (iter_q == 5'd1) begin
						state_q <= S_COMMIT;
					end else begin
						iter_q <= iter_q + 5'd1;
					end
				end
				S_COMMIT: begin
					for (int r = 0; r < 4; r++) begin
						for (int c = 0; c < 4; c++) begin
							m_q[r][c] <= next_q[r*4 + c];
						end
					end
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					out_item.row_index <= row_q;
					out_item.col_zero  <= m_q[row_q][0];
					out_item.col_one   <= m_q[row_q][1];
					out_item.col_two   <= m_q[row_q][2];
					out_item.col_three <= m_q[row_q][3];
					out_item.saturated <= sat_q;
					out_item.last_row  <= (row_q == 2'd3);
					out_valid          <= 1'b1;
					state_q            <= S_EMIT;
				end
				S_EMIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						row_q     <= row_q + 2'd1;
						state_q   <= (row_q == 2'd3) ? S_IDLE : S_LOAD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_MAC && v_s2 && ovf) sat_q <= 1'b1;
		end
	end

	a_no_out_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("output valid while accepting items");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready again right after accepting an item");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_item.last_row) |=> in_ready)
		else $error("not idle after last row");

endmodule
